// ===== rtl/irpwbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpwbl_pkg: shared types and constants of the infrared byte link
// Register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package irpwbl_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_ZERO          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_ONE           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_ZERO          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_ONE           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TIMEOUT         = 3'd5;

	localparam logic [15:0] RST_CARRIER_HALF_PERIOD = 16'd658;
	localparam logic [23:0] RST_BURST_ZERO          = 24'd30000;
	localparam logic [23:0] RST_BURST_ONE           = 24'd15000;
	localparam logic [23:0] RST_QUIET_ZERO          = 24'd30000;
	localparam logic [23:0] RST_QUIET_ONE           = 24'd15000;
	localparam logic [31:0] RST_LOW_TIMEOUT         = 32'd65800000;

	localparam logic [2:0] LAST_BIT_INDEX = 3'd7;

	typedef struct packed {
		logic [15:0] carrier_half_period;
		logic [23:0] burst_zero;
		logic [23:0] burst_one;
		logic [23:0] quiet_zero;
		logic [23:0] quiet_one;
		logic [31:0] low_timeout;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/irpwbl_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpwbl_cfg: configuration register file
// Holds the six timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module irpwbl_cfg
	import irpwbl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.carrier_half_period <= RST_CARRIER_HALF_PERIOD;
			regs_q.burst_zero          <= RST_BURST_ZERO;
			regs_q.burst_one           <= RST_BURST_ONE;
			regs_q.quiet_zero          <= RST_QUIET_ZERO;
			regs_q.quiet_one           <= RST_QUIET_ONE;
			regs_q.low_timeout         <= RST_LOW_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CARRIER_HALF_PERIOD: regs_q.carrier_half_period <= cfg_wdata[15:0];
				REG_BURST_ZERO:          regs_q.burst_zero <= cfg_wdata[23:0];
				REG_BURST_ONE:           regs_q.burst_one <= cfg_wdata[23:0];
				REG_QUIET_ZERO:          regs_q.quiet_zero <= cfg_wdata[23:0];
				REG_QUIET_ONE:           regs_q.quiet_one <= cfg_wdata[23:0];
				REG_LOW_TIMEOUT:         regs_q.low_timeout <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = regs_q;

endmodule
`default_nettype wire

// ===== rtl/irpwbl_tx.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpwbl_tx: pulse-width transmitter
// Lead-in, carrier burst and quiet gap sequencing, advanced one tick per item.
// ----------------------------------------------------------------------------
module irpwbl_tx
	import irpwbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cfg_t       cfg,
	input  logic       tx_start,
	input  logic [7:0] tx_byte,
	output logic       tx_level,
	output logic       tx_busy
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LEAD  = 2'd1;
	localparam logic [1:0] PH_BURST = 2'd2;
	localparam logic [1:0] PH_GAP   = 2'd3;

	logic [1:0]  ph_q, ph_d;
	logic [24:0] el_q, el_d;
	logic [15:0] ct_q, ct_d;
	logic        out_q, out_d;
	logic [7:0]  sh_q, sh_d;
	logic [2:0]  idx_q, idx_d;

	logic [24:0] lead_len;
	logic [16:0] half_len;
	logic [25:0] el_inc;
	logic [16:0] ct_inc;
	logic        cur_bit;
	logic [23:0] burst_len;
	logic [23:0] quiet_len;
	logic        adv_bit;

	assign lead_len = {1'b0, cfg.quiet_zero} + {1'b0, cfg.burst_zero};
	assign half_len = (cfg.carrier_half_period == 16'd0) ? 17'd1
		: {1'b0, cfg.carrier_half_period};

	always_comb begin
		ph_d = ph_q;
		el_d = el_q;
		ct_d = ct_q;
		out_d = out_q;
		sh_d = sh_q;
		idx_d = idx_q;
		tx_level = 1'b0;
		adv_bit = 1'b0;

		if (ph_q == PH_IDLE && tx_start) begin
			sh_d = tx_byte;
			idx_d = 3'd0;
			if (lead_len == 25'd0) begin
				ph_d = PH_BURST;
				el_d = 25'd0;
				ct_d = 16'd0;
				out_d = 1'b1;
			end else begin
				ph_d = PH_LEAD;
				el_d = 25'd0;
			end
		end

		tx_busy = (ph_d != PH_IDLE);
		cur_bit = sh_d[idx_d];
		burst_len = cur_bit ? cfg.burst_one : cfg.burst_zero;
		quiet_len = cur_bit ? cfg.quiet_one : cfg.quiet_zero;
		el_inc = {1'b0, el_d} + 26'd1;
		ct_inc = {1'b0, ct_d} + 17'd1;

		unique case (ph_d)
			PH_IDLE: begin
			end
			PH_LEAD: begin
				el_d = el_inc[24:0];
				if (el_inc >= {1'b0, lead_len}) begin
					ph_d = PH_BURST;
					el_d = 25'd0;
					ct_d = 16'd0;
					out_d = 1'b1;
				end
			end
			PH_BURST: begin
				tx_level = out_d;
				el_d = el_inc[24:0];
				ct_d = ct_inc[15:0];
				if (ct_inc >= half_len) begin
					ct_d = 16'd0;
					out_d = ~out_d;
					if (out_d && el_inc >= {2'b00, burst_len}) begin
						out_d = 1'b0;
						if (quiet_len == 24'd0) begin
							adv_bit = 1'b1;
						end else begin
							ph_d = PH_GAP;
							el_d = 25'd0;
						end
					end
				end
			end
			PH_GAP: begin
				el_d = el_inc[24:0];
				if (el_inc >= {2'b00, quiet_len}) begin
					adv_bit = 1'b1;
				end
			end
		endcase

		if (adv_bit) begin
			if (idx_d == LAST_BIT_INDEX) begin
				ph_d = PH_IDLE;
				idx_d = 3'd0;
				el_d = 25'd0;
				ct_d = 16'd0;
				out_d = 1'b0;
			end else begin
				idx_d = idx_d + 3'd1;
				ph_d = PH_BURST;
				el_d = 25'd0;
				ct_d = 16'd0;
				out_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			el_q <= 25'd0;
			ct_q <= 16'd0;
			out_q <= 1'b0;
			sh_q <= 8'd0;
			idx_q <= 3'd0;
		end else if (step) begin
			ph_q <= ph_d;
			el_q <= el_d;
			ct_q <= ct_d;
			out_q <= out_d;
			sh_q <= sh_d;
			idx_q <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/irpwbl_rx.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpwbl_rx: pulse-width receiver
// Times active-low pulses, decodes bits and assembles bytes LSB first.
// ----------------------------------------------------------------------------
module irpwbl_rx
	import irpwbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cfg_t       cfg,
	input  logic       rx_level,
	output logic [7:0] rx_byte,
	output logic       rx_valid,
	output logic       rx_timeout
);

	logic        inp_q, inp_d;
	logic [31:0] cnt_q, cnt_d;
	logic [7:0]  sh_q, sh_d;
	logic [2:0]  idx_q, idx_d;
	logic [7:0]  last_q, last_d;

	logic [24:0] burst_sum;
	logic [23:0] mean;
	logic        bit_val;

	assign burst_sum = {1'b0, cfg.burst_zero} + {1'b0, cfg.burst_one};
	assign mean = burst_sum[24:1];

	always_comb begin
		inp_d = inp_q;
		cnt_d = cnt_q;
		sh_d = sh_q;
		idx_d = idx_q;
		last_d = last_q;
		rx_valid = 1'b0;
		rx_timeout = 1'b0;
		bit_val = (cnt_q < {8'd0, mean});

		if (!rx_level) begin
			if (!inp_q) begin
				inp_d = 1'b1;
				cnt_d = 32'd1;
			end else if (cnt_q != 32'hFFFF_FFFF) begin
				cnt_d = cnt_q + 32'd1;
			end
			if ({1'b0, cnt_d} == ({1'b0, cfg.low_timeout} + 33'd1)) begin
				rx_timeout = 1'b1;
				sh_d = 8'd0;
				idx_d = 3'd0;
			end
		end else if (inp_q) begin
			inp_d = 1'b0;
			if (cnt_q <= cfg.low_timeout) begin
				if (idx_q == 3'd0) begin
					sh_d = 8'd0;
				end
				sh_d[idx_q] = sh_d[idx_q] | bit_val;
				if (idx_q == LAST_BIT_INDEX) begin
					idx_d = 3'd0;
					last_d = sh_d;
					rx_valid = 1'b1;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end
			cnt_d = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inp_q <= 1'b0;
			cnt_q <= 32'd0;
			sh_q <= 8'd0;
			idx_q <= 3'd0;
			last_q <= 8'd0;
		end else if (step) begin
			inp_q <= inp_d;
			cnt_q <= cnt_d;
			sh_q <= sh_d;
			idx_q <= idx_d;
			last_q <= last_d;
		end
	end

	assign rx_byte = last_d;

endmodule
`default_nettype wire

// ===== rtl/ir_pulse_width_byte_link_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_width_byte_link_top: infrared byte link, pulse-width coded
// Each input item is one tick of the transmitter and receiver timing.
// ----------------------------------------------------------------------------
// The block takes one item every clock cycle while no result waits for m_axis_tready
// and returns exactly one result item for each, in order; an accepted item is held
// in the input register, passes the single tick of transmitter and receiver logic,
// and its result is held in the result register that drives the master side.
// A result that waits for m_axis_tready keeps the next item in the input register
// and stalls the slave side until it is taken. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata; the user must write them only while no
// item is in flight, since the block itself does not enforce it.
module ir_pulse_width_byte_link_top
	import irpwbl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: rx_level, tx_start, tx_byte[7:0], zero fill.
	input  logic [15:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: tx_level, tx_busy, rx_byte[7:0], rx_valid, rx_timeout, zero fill.
	output logic [15:0]           m_axis_tdata
);

	cfg_t cfg;

	logic       valid_s1;
	logic       rx_level_s1;
	logic       tx_start_s1;
	logic [7:0] tx_byte_s1;
	logic       step;
	logic       in_take;

	logic       tx_level;
	logic       tx_busy;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       rx_timeout;

	logic        out_valid_q;
	logic [11:0] out_data_q;

	assign step = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign in_take = s_axis_tvalid && s_axis_tready;

	irpwbl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	irpwbl_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cfg      (cfg),
		.tx_start (tx_start_s1),
		.tx_byte  (tx_byte_s1),
		.tx_level (tx_level),
		.tx_busy  (tx_busy)
	);

	irpwbl_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.cfg        (cfg),
		.rx_level   (rx_level_s1),
		.rx_byte    (rx_byte),
		.rx_valid   (rx_valid),
		.rx_timeout (rx_timeout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_level_s1 <= s_axis_tdata[0];
			tx_start_s1 <= s_axis_tdata[1];
			tx_byte_s1 <= s_axis_tdata[9:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {rx_timeout, rx_valid, rx_byte, tx_busy, tx_level};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'd0, out_data_q};

endmodule
`default_nettype wire
